// ----- sv/expression_lexer_defines.svh -----
// ----------------------------------------------------------------------------
// expression_lexer_defines.svh
// Assertion macros shared by the lexer RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_LEXER_DEFINES_SVH
`define EXPRESSION_LEXER_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, checked on every edge outside reset.
`define EXL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a result in the next.
`define EXL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EXL_ASSERT(label, clk, rst_n, prop, msg)
`define EXL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/exl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_pkg
// Token codes, character constants and token record for the expression lexer.
// ----------------------------------------------------------------------------
package exl_pkg;

    localparam int FIELD_W     = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int ADDR_W      = 3;

    // register index, taken from paddr[2]
    localparam logic REG_SKIP_COMMENTS = 1'b0;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_STAR = 3'd3,
        MODE_NOTE = 3'd4
    } t_mode;

    typedef enum logic [4:0] {
        K_LPAREN = 5'd0,
        K_RPAREN = 5'd1,
        K_PLUS   = 5'd2,
        K_MINUS  = 5'd3,
        K_MULT   = 5'd4,
        K_DIV    = 5'd5,
        K_POW    = 5'd6,
        K_NUM    = 5'd7,
        K_ERR    = 5'd8,
        K_END    = 5'd9,
        K_ID     = 5'd10,
        K_SIN    = 5'd11,
        K_COS    = 5'd12,
        K_LOG    = 5'd13,
        K_PI     = 5'd14,
        K_E      = 5'd15,
        K_SEMI   = 5'd16
    } t_kind;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // keyword spellings, packed one byte per character
    localparam logic [23:0] KW_SIN = 24'h73696E;
    localparam logic [23:0] KW_COS = 24'h636F73;
    localparam logic [23:0] KW_LOG = 24'h6C6F67;
    localparam logic [23:0] KW_PI  = 24'h007069;
    localparam logic [23:0] KW_E   = 24'h000065;

    typedef struct packed {
        t_kind               kind;
        logic [FIELD_W-1:0]  start;
        logic [FIELD_W-1:0]  length;
        logic [FIELD_W-1:0]  line;
        logic [7:0]          ch;
        logic                last;
    } t_token;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic t_token make_tok(input t_kind kind, input logic [FIELD_W-1:0] start,
                                        input logic [FIELD_W-1:0] length,
                                        input logic [FIELD_W-1:0] line,
                                        input logic [7:0] ch);
        t_token t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.line   = line;
        t.ch     = ch;
        t.last   = 1'b0;
        make_tok = t;
    endfunction

endpackage

// ----- sv/expression_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_lexer
// Streaming lexer for a small expression language, one byte per transfer.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry one text byte i_ch per transfer;
// byte 0 ends the text. Output channel: o_valid / i_ready carry one token
// per transfer (kind, start, length, line, first byte, last_of_run).
// A byte produces zero, one or two tokens. The scanner step is
// combinational compare logic on the scanner state; its tokens are
// registered into a four-entry queue whose head drives the output ports.
// Sustained rate is one byte per cycle while the queue has room; bytes
// that yield two tokens are bounded by the output side at one token per
// cycle. o_ready drops while the queue has fewer than two free entries,
// so a stalled receiver stops input after at most four tokens.
// After END the scanner returns to its reset state; skip_comments keeps
// its value. Reset (synchronous, active low) empties the queue, clears
// the scanner and sets skip_comments to 1. The APB register at address 0
// holds skip_comments; write it only while the lexer is idle.
// ----------------------------------------------------------------------------
module expression_lexer
    import exl_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_ch,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [4:0]          o_token_kind,
    output logic [FIELD_W-1:0]  o_token_start,
    output logic [FIELD_W-1:0]  o_token_length,
    output logic [FIELD_W-1:0]  o_token_line,
    output logic [7:0]          o_token_char,
    output logic                o_last_of_run,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic        r_skip_comments;
    logic        w_fire;
    logic        w_space;
    logic [1:0]  w_num;
    t_token      w_tok0;
    t_token      w_tok1;
    t_token      w_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SKIP_COMMENTS) ? {31'b0, r_skip_comments} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_comments <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_SKIP_COMMENTS)) begin
            r_skip_comments <= pwdata[0];
        end
    end

    assign o_ready = w_space;
    assign w_fire  = i_valid && w_space;

    exl_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_ch            (i_ch),
        .i_skip_comments (r_skip_comments),
        .o_num           (w_num),
        .o_tok0          (w_tok0),
        .o_tok1          (w_tok1)
    );

    exl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (w_num),
        .i_tok0  (w_tok0),
        .i_tok1  (w_tok1),
        .o_space (w_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_tok   (w_head)
    );

    assign o_token_kind   = w_head.kind;
    assign o_token_start  = w_head.start;
    assign o_token_length = w_head.length;
    assign o_token_line   = w_head.line;
    assign o_token_char   = w_head.ch;
    assign o_last_of_run  = w_head.last;

endmodule

// ----- sv/exl_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_scan
// Scanner state and one-character step; produces up to two tokens per byte.
// ----------------------------------------------------------------------------
`include "expression_lexer_defines.svh"

module exl_scan
    import exl_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_ch,
    input  logic        i_skip_comments,
    output logic [1:0]  o_num,
    output t_token      o_tok0,
    output t_token      o_tok1
);

    t_mode                r_mode,   n_mode;
    logic [23:0]          r_prefix, n_prefix;
    logic                 r_seen,   n_seen;
    logic [POS_BITS-1:0]  r_start,  n_start;
    logic [POS_BITS-1:0]  r_len,    n_len;
    logic [7:0]           r_open,   n_open;
    logic [POS_BITS-1:0]  r_pos,    n_pos;
    logic [POS_BITS-1:0]  r_line,   n_line;

    logic w_alnum;
    logic w_extend;
    logic w_rescan;
    logic w_ended;
    logic w_lf;

    logic [FIELD_W-1:0] w_pos16;
    logic [FIELD_W-1:0] w_line16;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] x);
        sat_inc = (x == {POS_BITS{1'b1}}) ? x : x + POS_BITS'(1);
    endfunction

    assign w_alnum  = is_alpha(i_ch) || is_digit(i_ch);
    assign w_lf     = (i_ch == CH_LF);
    assign w_pos16  = FIELD_W'(r_pos);
    assign w_line16 = FIELD_W'(r_line);

    assign w_extend = ((r_mode == MODE_WORD) && w_alnum)
                   || ((r_mode == MODE_NUM)
                       && (is_digit(i_ch) || ((i_ch == CH_POINT) && !r_seen)));

    always_comb begin
        case (r_mode)
            MODE_NOTE: w_rescan = 1'b0;
            MODE_STAR: w_rescan = (i_ch != CH_STAR);
            MODE_WORD: w_rescan = !w_extend;
            MODE_NUM:  w_rescan = !w_extend;
            default:   w_rescan = 1'b1;
        endcase
    end

    assign w_ended = (i_ch == CH_NUL) && (w_rescan || (r_mode == MODE_NOTE));

    // ---------------- token outputs ----------------
    always_comb begin
        logic   a_vld;
        logic   b_vld;
        t_token a_tok;
        t_token b_tok;
        t_kind  wkind;

        a_vld = 1'b0;
        b_vld = 1'b0;
        a_tok = '0;
        b_tok = '0;

        // word classification on the prefix seen so far
        wkind = K_ID;
        if (r_len == POS_BITS'(3)) begin
            if (r_prefix == KW_SIN) wkind = K_SIN;
            else if (r_prefix == KW_COS) wkind = K_COS;
            else if (r_prefix == KW_LOG) wkind = K_LOG;
        end else if (r_len == POS_BITS'(2)) begin
            if (r_prefix == KW_PI) wkind = K_PI;
        end else if (r_len == POS_BITS'(1)) begin
            if (r_prefix == KW_E) wkind = K_E;
        end

        // token that closes the current lexeme
        case (r_mode)
            MODE_NOTE: begin
                if (i_ch == CH_NUL) begin
                    a_vld = 1'b1;
                    a_tok = make_tok(K_END, w_pos16, '0, w_line16, CH_NUL);
                end
            end
            MODE_STAR: begin
                a_vld = 1'b1;
                if (i_ch == CH_STAR) begin
                    a_tok = make_tok(K_POW, FIELD_W'(r_start), FIELD_W'(2), w_line16, CH_STAR);
                end else begin
                    a_tok = make_tok(K_MULT, FIELD_W'(r_start), FIELD_W'(1), w_line16,
                                     CH_STAR);
                end
            end
            MODE_WORD: begin
                if (!w_extend) begin
                    a_vld = 1'b1;
                    a_tok = make_tok(wkind, FIELD_W'(r_start), FIELD_W'(r_len), w_line16,
                                     r_open);
                end
            end
            MODE_NUM: begin
                if (!w_extend) begin
                    a_vld = 1'b1;
                    a_tok = make_tok(K_NUM, FIELD_W'(r_start), FIELD_W'(r_len), w_line16,
                                     r_open);
                end
            end
            default: begin
                a_vld = 1'b0;
            end
        endcase

        // the byte scanned again from idle
        if (w_rescan) begin
            case (i_ch)
                CH_NUL: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_END, w_pos16, '0, w_line16, CH_NUL);
                end
                CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_STAR: begin
                    b_vld = 1'b0;
                end
                CH_HASH: begin
                    b_vld = !i_skip_comments;
                    b_tok = make_tok(K_ERR, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                CH_LPAREN: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_LPAREN, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                CH_RPAREN: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_RPAREN, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                CH_PLUS: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_PLUS, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                CH_MINUS: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_MINUS, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                CH_SEMI: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_SEMI, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                CH_SLASH: begin
                    b_vld = 1'b1;
                    b_tok = make_tok(K_DIV, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
                default: begin
                    b_vld = !w_alnum;
                    b_tok = make_tok(K_ERR, w_pos16, FIELD_W'(1), w_line16, i_ch);
                end
            endcase
        end

        if (a_vld) begin
            o_tok0 = a_tok;
            o_tok1 = b_tok;
            o_num  = b_vld ? 2'd2 : 2'd1;
        end else begin
            o_tok0 = b_tok;
            o_tok1 = '0;
            o_num  = b_vld ? 2'd1 : 2'd0;
        end
        if (!i_fire) begin
            o_num = 2'd0;
        end
        o_tok0.last = (o_num == 2'd1);
        o_tok1.last = 1'b1;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_mode   = r_mode;
        n_prefix = r_prefix;
        n_seen   = r_seen;
        n_start  = r_start;
        n_len    = r_len;
        n_open   = r_open;
        n_pos    = sat_inc(r_pos);
        n_line   = r_line;

        if (w_lf && (w_rescan || (r_mode == MODE_NOTE))) begin
            n_line = sat_inc(r_line);
        end

        if ((r_mode == MODE_NOTE) && w_lf) begin
            n_mode = MODE_IDLE;
        end
        if ((r_mode == MODE_STAR) && !w_rescan) begin
            n_mode = MODE_IDLE;
        end

        if (w_extend) begin
            if (r_len < POS_BITS'(3)) begin
                n_prefix = {r_prefix[15:0], i_ch};
            end
            n_len = sat_inc(r_len);
            if (i_ch == CH_POINT) begin
                n_seen = 1'b1;
            end
        end

        if (w_rescan) begin
            n_mode = MODE_IDLE;
            if ((i_ch == CH_HASH) && i_skip_comments) begin
                n_mode = MODE_NOTE;
            end else if ((i_ch == CH_STAR) || w_alnum) begin
                if (i_ch == CH_STAR) n_mode = MODE_STAR;
                else if (is_alpha(i_ch)) n_mode = MODE_WORD;
                else n_mode = MODE_NUM;
                n_start  = r_pos;
                n_len    = POS_BITS'(1);
                n_open   = i_ch;
                n_prefix = {16'h0000, i_ch};
                n_seen   = 1'b0;
            end
        end

        if (w_ended) begin
            n_mode   = MODE_IDLE;
            n_prefix = '0;
            n_seen   = 1'b0;
            n_start  = '0;
            n_len    = '0;
            n_open   = '0;
            n_pos    = '0;
            n_line   = POS_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_prefix <= '0;
            r_seen   <= 1'b0;
            r_start  <= '0;
            r_len    <= '0;
            r_open   <= '0;
            r_pos    <= '0;
            r_line   <= POS_BITS'(1);
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_prefix <= n_prefix;
            r_seen   <= n_seen;
            r_start  <= n_start;
            r_len    <= n_len;
            r_open   <= n_open;
            r_pos    <= n_pos;
            r_line   <= n_line;
        end
    end

    `EXL_ASSERT(a_scan_pair_on_rescan, i_clk, i_rst_n, (o_num == 2'd2) |-> (w_rescan && !o_tok0.last && o_tok1.last), "two tokens without a rescan")
    `EXL_ASSERT(a_scan_end_is_final, i_clk, i_rst_n, (o_num == 2'd2) |-> (o_tok0.kind != K_END), "token after END in one step")
    `EXL_ASSERT_NEXT(a_scan_end_clears, i_clk, i_rst_n, i_fire && w_ended, (r_pos == '0) && (r_line == POS_BITS'(1)) && (r_mode == MODE_IDLE), "state not cleared after END")

endmodule

// ----- sv/exl_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exl_fifo
// Small token queue; takes zero, one or two tokens per cycle, gives at most one.
// ----------------------------------------------------------------------------
`include "expression_lexer_defines.svh"

module exl_fifo
    import exl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_num,
    input  t_token      i_tok0,
    input  t_token      i_tok1,
    output logic        o_space,
    output logic        o_valid,
    input  logic        i_ready,
    output t_token      o_tok
);

    t_token              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr, n_wr;
    logic [PTR_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PTR_W-1:0]    w_wr_nxt;
    logic                w_pop;

    assign o_valid  = (r_count != '0);
    assign o_tok    = r_mem[r_rd];
    assign w_pop    = o_valid && i_ready;
    // room for a two-token step
    assign o_space  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign w_wr_nxt = r_wr + PTR_W'(1);

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_num);
        n_rd    = w_pop ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + CNT_W'(i_num) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_num != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_num == 2'd2) begin
            r_mem[w_wr_nxt] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `EXL_ASSERT(a_fifo_no_overflow, i_clk, i_rst_n, (i_num != 2'd0) |-> (r_count <= CNT_W'(FIFO_DEPTH - 2)), "push without room for two tokens")
    `EXL_ASSERT(a_fifo_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(FIFO_DEPTH), "queue count past depth")
    `EXL_ASSERT_NEXT(a_fifo_pop_only, i_clk, i_rst_n, w_pop && (i_num == 2'd0), r_count == $past(r_count) - CNT_W'(1), "pop did not lower the count")

endmodule
